// ===== rtl/hnmt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hnmt_pkg
// Shared constants, codes and types of the hashed node mirror table.
// ----------------------------------------------------------------------------
package hnmt_pkg;

   localparam int MAX_NODES = 1024;
   localparam int BUCKETS   = 2048;
   localparam int SLOT_W    = $clog2(MAX_NODES);
   localparam int FL_W      = $clog2(MAX_NODES + 1);
   localparam int CNT_W     = $clog2(MAX_NODES + 1);
   localparam int BKT_W     = $clog2(BUCKETS);

   localparam logic [31:0] HASH_MUL = 32'h045d_9f3b;
   localparam logic [31:0] NONE_ID  = 32'hFFFF_FFFF;

   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_MOVE   = 2'd2;
   localparam logic [1:0] ACT_READ   = 2'd3;

   localparam logic [1:0] STS_DONE     = 2'd0;
   localparam logic [1:0] STS_DROP     = 2'd1;
   localparam logic [1:0] STS_UNKNOWN  = 2'd2;
   localparam logic [1:0] STS_MOVE_ADD = 2'd3;

   typedef enum logic {
      LM_FIND,
      LM_EMPTY
   } lmode_type;

   typedef struct packed {
      logic              valid;
      logic [31:0]       key;
      logic [SLOT_W-1:0] slot;
   } bucket_type;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] parent;
      logic [31:0] prev;
      logic [31:0] next;
      logic [31:0] head;
      logic        group;
   } rec_type;

   typedef enum logic [5:0] {
      S_CLEAR, S_IDLE,
      S_LHASH, S_LHOME, S_LPROBE,
      S_ADD0, S_ADD1,
      S_PAT0, S_PAT1, S_PAT2, S_PAT3, S_PAT4, S_PAT5,
      S_REM0, S_REM1, S_REM2, S_REM3, S_REM3W, S_REM4, S_REM5, S_REM5W,
      S_REM6, S_REM7, S_REM8, S_UCLR, S_UCHK, S_UCMP, S_REM9,
      S_MOV0, S_MOV1, S_MOV2, S_MOV3, S_MOV4, S_MOV5, S_MOV6, S_MOV7,
      S_MOV8, S_MOV9, S_MOV10,
      S_RD0, S_RD1, S_DONE
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/hnmt_hash.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hnmt_hash
// Home bucket of a key: fold, multiply (registered), fold again, mask.
// The home bucket appears in the cycle after the key.
// ----------------------------------------------------------------------------
module hnmt_hash import hnmt_pkg::*; (
   input  wire logic             clock,
   input  wire logic [31:0]      key,
   output logic      [BKT_W-1:0] home
);

   logic [31:0] mixed;
   logic [31:0] prod_in;
   logic [31:0] prod_ff;
   logic [31:0] fold;

   assign mixed   = key ^ (key >> 16);
   assign prod_in = 32'(mixed * HASH_MUL);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign fold = prod_ff ^ (prod_ff >> 16);
   assign home = fold[BKT_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/hashed_node_mirror_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_node_mirror_table
// Node table with a free list and a linear-probing hash of node ids.
// ----------------------------------------------------------------------------
// Throughput: one item at a time; add, remove and move make one id lookup
// per id they touch. The hash bucket port, one probe per cycle, and the
// shared hash multiplier set the pace of each lookup.
// Reset: a clearing pass over all 2048 buckets empties the buckets and slot
// flags; no item is taken until it ends.
// ----------------------------------------------------------------------------
module hashed_node_mirror_table import hnmt_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_action,
   input  wire logic signed [31:0] req_node_id,
   input  wire logic signed [31:0] req_parent_id,
   input  wire logic signed [31:0] req_prev_id,
   input  wire logic signed [31:0] req_next_id,
   input  wire logic signed [31:0] req_head_id,
   input  wire logic               req_is_group,
   input  wire logic [9:0]         req_slot_index,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [9:0]              rsp_slot,
   output logic [10:0]             rsp_node_count,
   output logic [31:0]             rsp_dropped_count,
   output logic [31:0]             rsp_version,
   output logic                    rsp_entry_valid,
   output logic signed [31:0]      rsp_entry_id,
   output logic signed [31:0]      rsp_entry_parent,
   output logic signed [31:0]      rsp_entry_prev,
   output logic signed [31:0]      rsp_entry_next,
   output logic signed [31:0]      rsp_entry_head,
   output logic                    rsp_entry_group
);

   // Storage.
   bucket_type        bkt_mem  [BUCKETS];
   logic              used_mem [MAX_NODES];
   logic [31:0]       id_mem   [MAX_NODES];
   logic [31:0]       par_mem  [MAX_NODES];
   logic [31:0]       prev_mem [MAX_NODES];
   logic [31:0]       next_mem [MAX_NODES];
   logic [31:0]       head_mem [MAX_NODES];
   logic              grp_mem  [MAX_NODES];
   logic [FL_W-1:0]   fn_mem   [MAX_NODES];

   state_type state_ff, state_in;

   // Item registers.
   logic [1:0]        act_ff, act_in;
   logic [31:0]       v0_ff, v0_in, v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic [31:0]       v4_ff, v4_in;
   logic              grp_ff, grp_in;
   logic [9:0]        idx_ff, idx_in;
   logic [1:0]        status_ff, status_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] s_ff, s_in;
   logic [BKT_W-1:0]  bkt_s_ff, bkt_s_in;
   logic [31:0]       oprev_ff, oprev_in, onext_ff, onext_in, opar_ff, opar_in;
   rec_type           ent_ff, ent_in;
   logic              entv_ff, entv_in;

   // Lookup unit.
   logic [31:0]       lkey_ff, lkey_in;
   lmode_type         lmode_ff, lmode_in;
   state_type         lret_ff, lret_in;
   logic [BKT_W-1:0]  lidx_ff, lidx_in;
   logic [BKT_W-1:0]  lcnt_ff, lcnt_in;
   logic              lfound_ff, lfound_in;
   logic [SLOT_W-1:0] lslot_ff, lslot_in;
   logic [BKT_W-1:0]  lbkt_ff, lbkt_in;
   logic              lhit;
   logic              ldone;

   // Backward-shift deletion.
   logic [BKT_W-1:0]  ui_ff, ui_in, uj_ff, uj_in;
   logic [31:0]       ujkey_ff, ujkey_in;
   logic [SLOT_W-1:0] ujslot_ff, ujslot_in;
   logic              ustay;

   // Free list and counters.
   logic [FL_W-1:0]   head_ff, head_in, fresh_ff, fresh_in;
   logic [FL_W-1:0]   fn_rd_ff;
   logic [CNT_W-1:0]  nodes_ff, nodes_in;
   logic [31:0]       dropped_ff, dropped_in, version_ff, version_in;
   logic [BKT_W-1:0]  clr_ff, clr_in;

   // Memory ports.
   logic              bkt_we;
   logic [BKT_W-1:0]  bkt_waddr, bkt_raddr;
   bucket_type        bkt_wdata, bkt_rd_ff;
   logic [SLOT_W-1:0] rec_waddr, rec_raddr;
   logic              we_id, we_par, we_prev, we_next, we_head, we_grp, we_used;
   logic [31:0]       w_prev, w_next, w_head;
   logic              w_used;
   rec_type           rec_rd_ff;
   logic              used_rd_ff;
   logic              fn_we;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [9:0]        rsp_slot_ff, rsp_slot_in;
   logic [CNT_W-1:0]  rsp_nodes_ff, rsp_nodes_in;
   logic [31:0]       rsp_dropped_ff, rsp_dropped_in, rsp_version_ff, rsp_version_in;
   logic              rsp_ev_ff, rsp_ev_in;
   rec_type           rsp_ent_ff, rsp_ent_in;
   logic              rsp_load;

   logic [31:0]       hash_key;
   logic [BKT_W-1:0]  home;

   hnmt_hash u_hash (
      .clock (clock),
      .key   (hash_key),
      .home  (home)
   );

   assign hash_key = (state_ff == S_UCHK) ? bkt_rd_ff.key : lkey_ff;

   assign lhit  = (lmode_ff == LM_FIND) && bkt_rd_ff.valid && (bkt_rd_ff.key == lkey_ff);
   assign ldone = !bkt_rd_ff.valid || lhit || (lcnt_ff == BKT_W'(BUCKETS - 1));

   // The entry at uj stays in the probe run when its home lies cyclically in (ui, uj].
   assign ustay = (ui_ff <= uj_ff) ? ((ui_ff < home) && (home <= uj_ff))
                                   : ((ui_ff < home) || (home <= uj_ff));

   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff != S_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:  if (clr_ff == BKT_W'(BUCKETS - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               case (req_action)
                  ACT_ADD:    state_in = S_ADD0;
                  ACT_REMOVE: state_in = S_REM0;
                  ACT_MOVE:   state_in = S_MOV0;
                  default:    state_in = S_RD0;
               endcase
            end
         end
         S_LHASH:  state_in = S_LHOME;
         S_LHOME:  state_in = S_LPROBE;
         S_LPROBE: if (ldone) state_in = lret_ff;
         S_ADD0:   state_in = (head_ff >= FL_W'(MAX_NODES)) ? S_DONE : S_LHASH;
         S_ADD1:   state_in = lfound_ff ? S_PAT0 : S_DONE;
         S_PAT0:   state_in = (v2_ff != NONE_ID) ? S_LHASH : S_PAT2;
         S_PAT1:   state_in = S_PAT2;
         S_PAT2:   state_in = (v3_ff != NONE_ID) ? S_LHASH : S_PAT4;
         S_PAT3:   state_in = S_PAT4;
         S_PAT4:   state_in = (v1_ff != NONE_ID && v2_ff == NONE_ID) ? S_LHASH : S_DONE;
         S_PAT5:   state_in = S_DONE;
         S_REM0:   state_in = S_LHASH;
         S_REM1:   state_in = lfound_ff ? S_REM2 : S_DONE;
         S_REM2:   state_in = (rec_rd_ff.prev != NONE_ID) ? S_LHASH : S_REM4;
         S_REM3:   state_in = S_REM3W;
         S_REM3W:  state_in = S_REM4;
         S_REM4:   state_in = (rec_rd_ff.next != NONE_ID) ? S_LHASH : S_REM6;
         S_REM5:   state_in = S_REM5W;
         S_REM5W:  state_in = S_REM6;
         S_REM6: begin
            state_in = (rec_rd_ff.parent != NONE_ID && rec_rd_ff.prev == NONE_ID)
                       ? S_LHASH : S_REM8;
         end
         S_REM7:   state_in = S_REM8;
         S_REM8:   state_in = S_UCLR;
         S_UCLR:   state_in = S_UCHK;
         S_UCHK:   state_in = bkt_rd_ff.valid ? S_UCMP : S_REM9;
         S_UCMP:   state_in = ustay ? S_UCHK : S_UCLR;
         S_REM9:   state_in = S_DONE;
         S_MOV0:   state_in = S_LHASH;
         S_MOV1:   state_in = lfound_ff ? S_MOV2 : S_ADD0;
         S_MOV2:   state_in = S_MOV3;
         S_MOV3:   state_in = (oprev_ff != NONE_ID) ? S_LHASH : S_MOV5;
         S_MOV4:   state_in = S_MOV5;
         S_MOV5:   state_in = (onext_ff != NONE_ID) ? S_LHASH : S_MOV7;
         S_MOV6:   state_in = S_MOV7;
         S_MOV7:   state_in = (opar_ff != NONE_ID && oprev_ff == NONE_ID) ? S_LHASH : S_MOV10;
         S_MOV8:   state_in = lfound_ff ? S_MOV9 : S_MOV10;
         S_MOV9:   state_in = S_MOV10;
         S_MOV10:  state_in = S_PAT0;
         S_RD0:    state_in = S_RD1;
         S_RD1:    state_in = S_DONE;
         S_DONE:   if (rsp_load) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      act_in     = act_ff;
      v0_in      = v0_ff;
      v1_in      = v1_ff;
      v2_in      = v2_ff;
      v3_in      = v3_ff;
      v4_in      = v4_ff;
      grp_in     = grp_ff;
      idx_in     = idx_ff;
      status_in  = status_ff;
      slot_in    = slot_ff;
      s_in       = s_ff;
      bkt_s_in   = bkt_s_ff;
      oprev_in   = oprev_ff;
      onext_in   = onext_ff;
      opar_in    = opar_ff;
      ent_in     = ent_ff;
      entv_in    = entv_ff;
      lkey_in    = lkey_ff;
      lmode_in   = lmode_ff;
      lret_in    = lret_ff;
      lidx_in    = lidx_ff;
      lcnt_in    = lcnt_ff;
      lfound_in  = lfound_ff;
      lslot_in   = lslot_ff;
      lbkt_in    = lbkt_ff;
      ui_in      = ui_ff;
      uj_in      = uj_ff;
      ujkey_in   = ujkey_ff;
      ujslot_in  = ujslot_ff;
      head_in    = head_ff;
      fresh_in   = fresh_ff;
      nodes_in   = nodes_ff;
      dropped_in = dropped_ff;
      version_in = version_ff;
      clr_in     = clr_ff;

      bkt_we    = 1'b0;
      bkt_waddr = ui_ff;
      bkt_wdata = '0;
      bkt_raddr = lidx_ff;
      rec_waddr = lslot_ff;
      rec_raddr = s_ff;
      we_id     = 1'b0;
      we_par    = 1'b0;
      we_prev   = 1'b0;
      we_next   = 1'b0;
      we_head   = 1'b0;
      we_grp    = 1'b0;
      we_used   = 1'b0;
      w_prev    = v0_ff;
      w_next    = v0_ff;
      w_head    = v0_ff;
      w_used    = 1'b0;
      fn_we     = 1'b0;

      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_nodes_in   = rsp_nodes_ff;
      rsp_dropped_in = rsp_dropped_ff;
      rsp_version_in = rsp_version_ff;
      rsp_ev_in      = rsp_ev_ff;
      rsp_ent_in     = rsp_ent_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            bkt_we    = 1'b1;
            bkt_waddr = clr_ff;
            rec_waddr = clr_ff[SLOT_W-1:0];
            we_used   = (32'(clr_ff) < MAX_NODES);
            clr_in    = clr_ff + 1'b1;
         end
         S_IDLE: begin
            if (req_valid) begin
               act_in    = req_action;
               v0_in     = req_node_id;
               v1_in     = req_parent_id;
               v2_in     = req_prev_id;
               v3_in     = req_next_id;
               v4_in     = req_head_id;
               grp_in    = req_is_group;
               idx_in    = req_slot_index;
               status_in = STS_DONE;
               slot_in   = '0;
            end
         end
         S_LHOME: begin
            bkt_raddr = home;
            lidx_in   = home;
            lcnt_in   = '0;
         end
         S_LPROBE: begin
            if (ldone) begin
               lfound_in = lhit || (!bkt_rd_ff.valid && lmode_ff == LM_EMPTY);
               lslot_in  = bkt_rd_ff.slot;
               lbkt_in   = lidx_ff;
            end else begin
               bkt_raddr = lidx_ff + 1'b1;
               lidx_in   = lidx_ff + 1'b1;
               lcnt_in   = lcnt_ff + 1'b1;
            end
         end
         S_ADD0: begin
            lkey_in  = v0_ff;
            lmode_in = LM_EMPTY;
            lret_in  = S_ADD1;
            if (head_ff >= FL_W'(MAX_NODES)) begin
               dropped_in = dropped_ff + 1'b1;
               status_in  = STS_DROP;
            end
         end
         S_ADD1: begin
            if (!lfound_ff) begin
               dropped_in = dropped_ff + 1'b1;
               status_in  = STS_DROP;
            end else begin
               // A slot that was never handed out links to the one after it.
               if (head_ff == fresh_ff) begin
                  head_in  = head_ff + 1'b1;
                  fresh_in = fresh_ff + 1'b1;
               end else begin
                  head_in = fn_rd_ff;
               end
               s_in      = head_ff[SLOT_W-1:0];
               slot_in   = head_ff[SLOT_W-1:0];
               bkt_we    = 1'b1;
               bkt_waddr = lbkt_ff;
               bkt_wdata = '{valid: 1'b1, key: v0_ff, slot: head_ff[SLOT_W-1:0]};
               rec_waddr = head_ff[SLOT_W-1:0];
               we_id     = 1'b1;
               we_par    = 1'b1;
               we_prev   = 1'b1;
               we_next   = 1'b1;
               we_head   = 1'b1;
               we_grp    = 1'b1;
               we_used   = 1'b1;
               w_used    = 1'b1;
               w_prev    = v2_ff;
               w_next    = v3_ff;
               w_head    = grp_ff ? v4_ff : NONE_ID;
               if (nodes_ff < CNT_W'(MAX_NODES)) nodes_in = nodes_ff + 1'b1;
               version_in = version_ff + 1'b1;
               status_in  = (act_ff == ACT_MOVE) ? STS_MOVE_ADD : STS_DONE;
            end
         end
         S_PAT0: begin
            lkey_in  = v2_ff;
            lmode_in = LM_FIND;
            lret_in  = S_PAT1;
         end
         S_PAT1: we_next = lfound_ff;
         S_PAT2: begin
            lkey_in  = v3_ff;
            lmode_in = LM_FIND;
            lret_in  = S_PAT3;
         end
         S_PAT3: we_prev = lfound_ff;
         S_PAT4: begin
            lkey_in  = v1_ff;
            lmode_in = LM_FIND;
            lret_in  = S_PAT5;
         end
         S_PAT5: we_head = lfound_ff;
         S_REM0: begin
            lkey_in  = v0_ff;
            lmode_in = LM_FIND;
            lret_in  = S_REM1;
         end
         S_REM1: begin
            rec_raddr = lslot_ff;
            if (!lfound_ff) begin
               if (dropped_ff != '0) dropped_in = dropped_ff - 1'b1;
               status_in = STS_UNKNOWN;
            end else begin
               s_in     = lslot_ff;
               bkt_s_in = lbkt_ff;
            end
         end
         S_REM2: begin
            lkey_in  = rec_rd_ff.prev;
            lmode_in = LM_FIND;
            lret_in  = S_REM3;
         end
         S_REM3: begin
            we_next = lfound_ff;
            w_next  = rec_rd_ff.next;
         end
         S_REM4: begin
            lkey_in  = rec_rd_ff.next;
            lmode_in = LM_FIND;
            lret_in  = S_REM5;
         end
         S_REM5: begin
            we_prev = lfound_ff;
            w_prev  = rec_rd_ff.prev;
         end
         S_REM6: begin
            lkey_in  = rec_rd_ff.parent;
            lmode_in = LM_FIND;
            lret_in  = S_REM7;
         end
         S_REM7: begin
            we_head = lfound_ff;
            w_head  = rec_rd_ff.next;
         end
         S_REM8: ui_in = bkt_s_ff;
         S_UCLR: begin
            bkt_we    = 1'b1;
            bkt_waddr = ui_ff;
            bkt_raddr = ui_ff + 1'b1;
            uj_in     = ui_ff + 1'b1;
         end
         S_UCHK: begin
            bkt_raddr = uj_ff;
            ujkey_in  = bkt_rd_ff.key;
            ujslot_in = bkt_rd_ff.slot;
         end
         S_UCMP: begin
            if (ustay) begin
               bkt_raddr = uj_ff + 1'b1;
               uj_in     = uj_ff + 1'b1;
            end else begin
               bkt_we    = 1'b1;
               bkt_waddr = ui_ff;
               bkt_wdata = '{valid: 1'b1, key: ujkey_ff, slot: ujslot_ff};
               ui_in     = uj_ff;
            end
         end
         S_REM9: begin
            rec_waddr = s_ff;
            we_used   = 1'b1;
            fn_we     = 1'b1;
            head_in   = FL_W'(s_ff);
            if (nodes_ff != '0) nodes_in = nodes_ff - 1'b1;
            version_in = version_ff + 1'b1;
            slot_in    = s_ff;
         end
         S_MOV0: begin
            lkey_in  = v0_ff;
            lmode_in = LM_FIND;
            lret_in  = S_MOV1;
         end
         S_MOV1: begin
            rec_raddr = lslot_ff;
            if (lfound_ff) s_in = lslot_ff;
         end
         S_MOV2: begin
            oprev_in  = rec_rd_ff.prev;
            onext_in  = rec_rd_ff.next;
            opar_in   = rec_rd_ff.parent;
            rec_waddr = s_ff;
            we_par    = 1'b1;
            we_prev   = 1'b1;
            we_next   = 1'b1;
            we_head   = grp_ff;
            w_prev    = v2_ff;
            w_next    = v3_ff;
            w_head    = v4_ff;
         end
         S_MOV3: begin
            lkey_in  = oprev_ff;
            lmode_in = LM_FIND;
            lret_in  = S_MOV4;
         end
         S_MOV4: begin
            we_next = lfound_ff;
            w_next  = onext_ff;
         end
         S_MOV5: begin
            lkey_in  = onext_ff;
            lmode_in = LM_FIND;
            lret_in  = S_MOV6;
         end
         S_MOV6: begin
            we_prev = lfound_ff;
            w_prev  = oprev_ff;
         end
         S_MOV7: begin
            lkey_in  = opar_ff;
            lmode_in = LM_FIND;
            lret_in  = S_MOV8;
         end
         S_MOV8: rec_raddr = lslot_ff;
         S_MOV9: begin
            // The old parent keeps its head unless it still names this node.
            we_head = (rec_rd_ff.head == v0_ff);
            w_head  = onext_ff;
         end
         S_MOV10: begin
            version_in = version_ff + 1'b1;
            slot_in    = s_ff;
         end
         S_RD0: rec_raddr = idx_ff[SLOT_W-1:0];
         S_RD1: begin
            ent_in  = rec_rd_ff;
            entv_in = used_rd_ff && (32'(idx_ff) < MAX_NODES);
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_slot_in    = (act_ff == ACT_READ) ? idx_ff : 10'(slot_ff);
               rsp_nodes_in   = nodes_ff;
               rsp_dropped_in = dropped_ff;
               rsp_version_in = version_ff;
               rsp_ev_in      = (act_ff == ACT_READ) && entv_ff;
               rsp_ent_in     = ((act_ff == ACT_READ) && entv_ff) ? ent_ff : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         fresh_ff     <= '0;
         nodes_ff     <= '0;
         dropped_ff   <= '0;
         version_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         fresh_ff     <= fresh_in;
         nodes_ff     <= nodes_in;
         dropped_ff   <= dropped_in;
         version_ff   <= version_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      v0_ff          <= v0_in;
      v1_ff          <= v1_in;
      v2_ff          <= v2_in;
      v3_ff          <= v3_in;
      v4_ff          <= v4_in;
      grp_ff         <= grp_in;
      idx_ff         <= idx_in;
      status_ff      <= status_in;
      slot_ff        <= slot_in;
      s_ff           <= s_in;
      bkt_s_ff       <= bkt_s_in;
      oprev_ff       <= oprev_in;
      onext_ff       <= onext_in;
      opar_ff        <= opar_in;
      ent_ff         <= ent_in;
      entv_ff        <= entv_in;
      lkey_ff        <= lkey_in;
      lmode_ff       <= lmode_in;
      lret_ff        <= lret_in;
      lidx_ff        <= lidx_in;
      lcnt_ff        <= lcnt_in;
      lfound_ff      <= lfound_in;
      lslot_ff       <= lslot_in;
      lbkt_ff        <= lbkt_in;
      ui_ff          <= ui_in;
      uj_ff          <= uj_in;
      ujkey_ff       <= ujkey_in;
      ujslot_ff      <= ujslot_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_nodes_ff   <= rsp_nodes_in;
      rsp_dropped_ff <= rsp_dropped_in;
      rsp_version_ff <= rsp_version_in;
      rsp_ev_ff      <= rsp_ev_in;
      rsp_ent_ff     <= rsp_ent_in;
   end

   // Bucket memory.
   always_ff @(posedge clock) begin
      if (bkt_we) bkt_mem[bkt_waddr] <= bkt_wdata;
      bkt_rd_ff <= bkt_mem[bkt_raddr];
   end

   // Record memories, one per field, sharing the write and read addresses.
   always_ff @(posedge clock) begin
      if (we_id)   id_mem[rec_waddr]   <= v0_ff;
      if (we_par)  par_mem[rec_waddr]  <= v1_ff;
      if (we_prev) prev_mem[rec_waddr] <= w_prev;
      if (we_next) next_mem[rec_waddr] <= w_next;
      if (we_head) head_mem[rec_waddr] <= w_head;
      if (we_grp)  grp_mem[rec_waddr]  <= grp_ff;
      if (we_used) used_mem[rec_waddr] <= w_used;
      rec_rd_ff.id     <= id_mem[rec_raddr];
      rec_rd_ff.parent <= par_mem[rec_raddr];
      rec_rd_ff.prev   <= prev_mem[rec_raddr];
      rec_rd_ff.next   <= next_mem[rec_raddr];
      rec_rd_ff.head   <= head_mem[rec_raddr];
      rec_rd_ff.group  <= grp_mem[rec_raddr];
      used_rd_ff       <= used_mem[rec_raddr];
   end

   // Free list links, written only for slots that were released.
   always_ff @(posedge clock) begin
      if (fn_we) fn_mem[s_ff] <= head_ff;
      fn_rd_ff <= fn_mem[head_ff[SLOT_W-1:0]];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_node_count    = rsp_nodes_ff;
   assign rsp_dropped_count = rsp_dropped_ff;
   assign rsp_version       = rsp_version_ff;
   assign rsp_entry_valid   = rsp_ev_ff;
   assign rsp_entry_id      = rsp_ent_ff.id;
   assign rsp_entry_parent  = rsp_ent_ff.parent;
   assign rsp_entry_prev    = rsp_ent_ff.prev;
   assign rsp_entry_next    = rsp_ent_ff.next;
   assign rsp_entry_head    = rsp_ent_ff.head;
   assign rsp_entry_group   = rsp_ent_ff.group;

endmodule
`default_nettype wire

// ===== sim/hnmt_checker.sv =====
// ----------------------------------------------------------------------------
// hnmt_checker
// Watches both channels of the node mirror table, keeps a shadow of its
// table, hash and free list, and compares every response with the result
// worked out for the oldest accepted request.
// ----------------------------------------------------------------------------
module hnmt_checker import hnmt_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic [1:0]         req_action,
   input  wire logic signed [31:0] req_node_id,
   input  wire logic signed [31:0] req_parent_id,
   input  wire logic signed [31:0] req_prev_id,
   input  wire logic signed [31:0] req_next_id,
   input  wire logic signed [31:0] req_head_id,
   input  wire logic               req_is_group,
   input  wire logic [9:0]         req_slot_index,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic [1:0]         rsp_status,
   input  wire logic [9:0]         rsp_slot,
   input  wire logic [10:0]        rsp_node_count,
   input  wire logic [31:0]        rsp_dropped_count,
   input  wire logic [31:0]        rsp_version,
   input  wire logic               rsp_entry_valid,
   input  wire logic signed [31:0] rsp_entry_id,
   input  wire logic signed [31:0] rsp_entry_parent,
   input  wire logic signed [31:0] rsp_entry_prev,
   input  wire logic signed [31:0] rsp_entry_next,
   input  wire logic signed [31:0] rsp_entry_head,
   input  wire logic               rsp_entry_group,
   output int                      fail_count,
   output int                      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  slot;
      logic [10:0] node_count;
      logic [31:0] dropped;
      logic [31:0] version;
      logic        ev;
      logic [31:0] id, parent, prev, next, head;
      logic        group;
   } outcome_t;

   outcome_t   outcome_q[$];

   logic       bk_valid[BUCKETS];
   logic [31:0] bk_key[BUCKETS];
   logic [9:0] bk_slot[BUCKETS];
   logic [10:0] fr_next[MAX_NODES];
   logic [10:0] fr_head;
   logic       used[MAX_NODES];
   logic [31:0] r_id[MAX_NODES], r_par[MAX_NODES], r_prev[MAX_NODES];
   logic [31:0] r_next[MAX_NODES], r_head[MAX_NODES];
   logic       r_grp[MAX_NODES];
   logic [10:0] n_nodes;
   logic [31:0] n_drop, n_ver;

   function automatic logic [10:0] home(logic [31:0] key);
      logic [31:0] h;
      h = key ^ (key >> 16);
      h = h * HASH_MUL;
      h = h ^ (h >> 16);
      return h[10:0];
   endfunction

   // Returns -1 when the id is not mirrored.
   function automatic int find_slot(logic [31:0] key);
      logic [10:0] i;
      i = home(key);
      for (int n = 0; n < BUCKETS; n++) begin
         if (!bk_valid[i]) return -1;
         if (bk_key[i] == key) return int'(bk_slot[i]);
         i = i + 1;
      end
      return -1;
   endfunction

   function automatic void drop_bucket(logic [31:0] key);
      logic [10:0] i, j, r;
      bit hit;
      hit = 0;
      i = home(key);
      for (int n = 0; n < BUCKETS; n++) begin
         if (!bk_valid[i]) return;
         if (bk_key[i] == key) begin
            hit = 1;
            break;
         end
         i = i + 1;
      end
      if (!hit) return;
      // Backward-shift deletion: pull later entries into the hole.
      forever begin
         bk_valid[i] = 0;
         j = i;
         forever begin
            j = j + 1;
            if (!bk_valid[j]) return;
            r = home(bk_key[j]);
            if (i <= j ? (i < r && r <= j) : (i < r || r <= j)) continue;
            break;
         end
         bk_valid[i] = 1;
         bk_key[i] = bk_key[j];
         bk_slot[i] = bk_slot[j];
         i = j;
      end
   endfunction

   function automatic void link_in(logic [31:0] id, par, prv, nxt);
      int s;
      if (prv != NONE_ID) begin
         s = find_slot(prv);
         if (s >= 0) r_next[s] = id;
      end
      if (nxt != NONE_ID) begin
         s = find_slot(nxt);
         if (s >= 0) r_prev[s] = id;
      end
      if (par != NONE_ID && prv == NONE_ID) begin
         s = find_slot(par);
         if (s >= 0) r_head[s] = id;
      end
   endfunction

   function automatic bit insert_node(logic [31:0] id, par, prv, nxt, hd, logic grp,
                                      output logic [9:0] slot);
      int b;
      logic [10:0] i;
      slot = '0;
      if (fr_head >= MAX_NODES) begin
         n_drop++;
         return 0;
      end
      b = -1;
      i = home(id);
      for (int n = 0; n < BUCKETS; n++) begin
         if (!bk_valid[i]) begin
            b = i;
            break;
         end
         i = i + 1;
      end
      if (b < 0) begin
         n_drop++;
         return 0;
      end
      slot = fr_head[9:0];
      fr_head = fr_next[slot];
      used[slot] = 1;
      r_id[slot] = id;
      r_par[slot] = par;
      r_prev[slot] = prv;
      r_next[slot] = nxt;
      r_head[slot] = grp ? hd : NONE_ID;
      r_grp[slot] = grp;
      bk_valid[b] = 1;
      bk_key[b] = id;
      bk_slot[b] = slot;
      link_in(id, par, prv, nxt);
      if (n_nodes < MAX_NODES) n_nodes++;
      n_ver++;
      return 1;
   endfunction

   function automatic outcome_t apply_request(logic [1:0] act,
         logic [31:0] id, par, prv, nxt, hd, logic grp, logic [9:0] idx);
      outcome_t o;
      int s, t;
      logic [9:0] sl;
      logic [31:0] op, on, opar;
      o = '0;
      case (act)
         ACT_ADD: begin
            if (!insert_node(id, par, prv, nxt, hd, grp, sl)) o.status = STS_DROP;
            o.slot = sl;
         end
         ACT_REMOVE: begin
            s = find_slot(id);
            if (s < 0) begin
               if (n_drop != 0) n_drop--;
               o.status = STS_UNKNOWN;
            end else begin
               if (r_prev[s] != NONE_ID) begin
                  t = find_slot(r_prev[s]);
                  if (t >= 0) r_next[t] = r_next[s];
               end
               if (r_next[s] != NONE_ID) begin
                  t = find_slot(r_next[s]);
                  if (t >= 0) r_prev[t] = r_prev[s];
               end
               if (r_par[s] != NONE_ID && r_prev[s] == NONE_ID) begin
                  t = find_slot(r_par[s]);
                  if (t >= 0) r_head[t] = r_next[s];
               end
               drop_bucket(id);
               r_id[s] = NONE_ID;
               used[s] = 0;
               fr_next[s] = fr_head;
               fr_head = 11'(s);
               if (n_nodes != 0) n_nodes--;
               n_ver++;
               o.slot = 10'(s);
            end
         end
         ACT_MOVE: begin
            s = find_slot(id);
            if (s < 0) begin
               o.status = insert_node(id, par, prv, nxt, hd, grp, sl) ? STS_MOVE_ADD
                                                                      : STS_DROP;
               o.slot = sl;
            end else begin
               op = r_prev[s];
               on = r_next[s];
               opar = r_par[s];
               r_par[s] = par;
               r_prev[s] = prv;
               r_next[s] = nxt;
               if (grp) r_head[s] = hd;
               if (op != NONE_ID) begin
                  t = find_slot(op);
                  if (t >= 0) r_next[t] = on;
               end
               if (on != NONE_ID) begin
                  t = find_slot(on);
                  if (t >= 0) r_prev[t] = op;
               end
               if (opar != NONE_ID && op == NONE_ID) begin
                  t = find_slot(opar);
                  if (t >= 0 && r_head[t] == id) r_head[t] = on;
               end
               link_in(id, par, prv, nxt);
               n_ver++;
               o.slot = 10'(s);
            end
         end
         default: begin
            o.slot = idx;
            if (used[idx]) begin
               o.ev = 1;
               o.id = r_id[idx];
               o.parent = r_par[idx];
               o.prev = r_prev[idx];
               o.next = r_next[idx];
               o.head = r_head[idx];
               o.group = r_grp[idx];
            end
         end
      endcase
      o.node_count = n_nodes;
      o.dropped = n_drop;
      o.version = n_ver;
      return o;
   endfunction

   initial begin
      fail_count = 0;
      for (int b = 0; b < BUCKETS; b++) bk_valid[b] = 0;
      for (int k = 0; k < MAX_NODES; k++) begin
         fr_next[k] = 11'(k + 1);
         used[k] = 0;
      end
      fr_head = 0;
      n_nodes = 0;
      n_drop = 0;
      n_ver = 0;
   end

   assign pending = outcome_q.size();

   always @(posedge clock) begin
      outcome_t want, got;
      if (!reset) begin
         if (req_valid && !req_stall)
            outcome_q.push_back(apply_request(req_action, req_node_id, req_parent_id,
               req_prev_id, req_next_id, req_head_id, req_is_group, req_slot_index));
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_slot, rsp_node_count, rsp_dropped_count, rsp_version,
                   rsp_entry_valid, rsp_entry_id, rsp_entry_parent, rsp_entry_prev,
                   rsp_entry_next, rsp_entry_head, rsp_entry_group};
            if (outcome_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("response with none outstanding: %h", got);
            end else begin
               want = outcome_q.pop_front();
               if (got != want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch at %0t", $realtime);
                     $display("  exp st=%0d slot=%0d n=%0d drop=%0d ver=%0d v=%b",
                        want.status, want.slot, want.node_count, want.dropped,
                        want.version, want.ev);
                     $display("  exp id=%h par=%h prev=%h next=%h head=%h g=%b",
                        want.id, want.parent, want.prev, want.next, want.head, want.group);
                     $display("  got st=%0d slot=%0d n=%0d drop=%0d ver=%0d v=%b",
                        got.status, got.slot, got.node_count, got.dropped,
                        got.version, got.ev);
                     $display("  got id=%h par=%h prev=%h next=%h head=%h g=%b",
                        got.id, got.parent, got.prev, got.next, got.head, got.group);
                  end
               end
            end
         end
      end
   end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives add, remove, move and read requests into the node mirror table with
// random idle and stall patterns; the checker judges every response.
// ----------------------------------------------------------------------------
module tb_top import hnmt_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, rsp_stall = 0;
   logic [1:0] req_action = ACT_READ;
   logic signed [31:0] req_node_id = 0, req_parent_id = 0, req_prev_id = 0;
   logic signed [31:0] req_next_id = 0, req_head_id = 0;
   logic req_is_group = 0;
   logic [9:0] req_slot_index = 0;
   wire req_stall, rsp_valid;
   wire [1:0] rsp_status;
   wire [9:0] rsp_slot;
   wire [10:0] rsp_node_count;
   wire [31:0] rsp_dropped_count, rsp_version;
   wire rsp_entry_valid, rsp_entry_group;
   wire signed [31:0] rsp_entry_id, rsp_entry_parent, rsp_entry_prev;
   wire signed [31:0] rsp_entry_next, rsp_entry_head;
   int fail_count, pending;

   int send_idle_pct = 16, recv_idle_pct = 72;
   int hold_off = 0;
   longint cycles = 0;
   logic [31:0] live_ids[$];
   logic [31:0] id_pool[64];

   always #5 clock = ~clock;

   hashed_node_mirror_table dut (.*);
   hnmt_checker checker_i (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 64'd4_000_000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver: random stalls, or a long forced hold-off.
   always @(posedge clock) begin
      if (hold_off > 0) begin
         rsp_stall <= 1;
         hold_off <= hold_off - 1;
      end else
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   function automatic logic [31:0] pick_link();
      case ($urandom_range(3))
         0: return NONE_ID;
         1: return id_pool[$urandom_range(63)];
         default: return live_ids.size() ? live_ids[$urandom_range(live_ids.size() - 1)]
                                          : NONE_ID;
      endcase
   endfunction

   task automatic send(logic [1:0] a, logic [31:0] id, par, prv, nxt, hd, logic g,
                       logic [9:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_action <= a;
      req_node_id <= id;
      req_parent_id <= par;
      req_prev_id <= prv;
      req_next_id <= nxt;
      req_head_id <= hd;
      req_is_group <= g;
      req_slot_index <= idx;
      do @(posedge clock); while (req_stall);
      if (a == ACT_ADD) live_ids.push_back(id);
   endtask

   task automatic random_item();
      logic [31:0] id;
      int r;
      r = $urandom_range(99);
      if (live_ids.size() && $urandom_range(1))
         id = live_ids[$urandom_range(live_ids.size() - 1)];
      else if ($urandom_range(3) == 0)
         id = $urandom;
      else
         id = id_pool[$urandom_range(63)];
      if (r < 40)
         send(ACT_ADD, id, pick_link(), pick_link(), pick_link(), $urandom, $urandom,
              $urandom);
      else if (r < 60)
         send(ACT_REMOVE, id, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (r < 80)
         send(ACT_MOVE, id, pick_link(), pick_link(), pick_link(), $urandom, $urandom,
              $urandom);
      else
         send(ACT_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom_range(r < 95 ? 40 : 1023));
   endtask

   initial begin
      for (int k = 0; k < 64; k++) id_pool[k] = $urandom;
      id_pool[0] = 32'h8000_0000;
      id_pool[1] = 32'h7FFF_FFFF;
      id_pool[2] = 0;
      repeat (6) @(posedge clock);
      reset <= 0;

      // Directed: a small family with self links and edge ids.
      send(ACT_ADD, 32'h8000_0000, NONE_ID, NONE_ID, NONE_ID, 32'h7FFF_FFFF, 1, 0);
      send(ACT_ADD, 32'h7FFF_FFFF, 32'h8000_0000, NONE_ID, NONE_ID, NONE_ID, 0, 10'h3FF);
      send(ACT_ADD, 5, 32'h8000_0000, 32'h7FFF_FFFF, NONE_ID, 9, 1, 0);
      send(ACT_ADD, 5, 5, 5, 5, 5, 1, 0);
      send(ACT_ADD, 0, NONE_ID, 5, 32'h7FFF_FFFF, 0, 0, 0);
      send(ACT_READ, 0, 0, 0, 0, 0, 0, 0);
      send(ACT_READ, 0, 0, 0, 0, 0, 0, 2);
      send(ACT_READ, 0, 0, 0, 0, 0, 0, 10'h3FF);
      send(ACT_MOVE, 32'h7FFF_FFFF, NONE_ID, 0, NONE_ID, 3, 1, 0);
      send(ACT_MOVE, 77, 32'h8000_0000, NONE_ID, 5, 1, 1, 0);
      send(ACT_MOVE, 5, 5, 5, 5, 5, 0, 0);
      send(ACT_REMOVE, 1234, 0, 0, 0, 0, 0, 0);
      send(ACT_REMOVE, 5, 0, 0, 0, 0, 0, 0);
      send(ACT_REMOVE, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
      for (int k = 0; k < 5; k++) send(ACT_READ, 0, 0, 0, 0, 0, 0, 10'(k));

      // Fill the table past full so adds are dropped, under a long stall.
      hold_off = 300;
      for (int k = 0; k < 1040; k++)
         send(ACT_ADD, $urandom, pick_link(), NONE_ID, NONE_ID, $urandom, $urandom, 0);
      for (int k = 0; k < 1030; k++) begin
         if (live_ids.size() == 0) break;
         send(ACT_REMOVE, live_ids.pop_front(), 0, 0, 0, 0, 0, 0);
      end
      live_ids.delete();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = phase == 0 ? 16 : phase == 1 ? 72 : 0;
         recv_idle_pct = phase == 0 ? 72 : phase == 1 ? 16 : 0;
         for (int k = 0; k < 470; k++) random_item();
      end
      req_valid <= 0;

      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/hnmt_pkg.sv
rtl/hnmt_hash.sv
rtl/hashed_node_mirror_table.sv
sim/hnmt_checker.sv
sim/tb_top.sv
